// ===== hw/rtl/xor_checked_frame_receiver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the XOR-checked frame receiver
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xcfr check failed");

// The consequent must hold in the cycle after the antecedent.
`define XCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xcfr check failed");

`endif

// ===== hw/rtl/xcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// XOR-checked frame receiver package
// Frame phases, event and reply codes, header bytes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfr_pkg;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_CMD    = 3'd1,
      PH_REQ    = 3'd2,
      PH_DATLEN = 3'd3,
      PH_DATVAR = 3'd4,
      PH_DAT    = 3'd5,
      PH_STAT   = 3'd6,
      PH_CHECK  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_CMD_OK  = 3'd2,
      EV_REQ_OK  = 3'd3,
      EV_DAT_OK  = 3'd4,
      EV_STATUS  = 3'd5,
      EV_TOOLONG = 3'd6,
      EV_BADCHK  = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      REPLY_NONE     = 2'd0,
      REPLY_RECEIVED = 2'd1,
      REPLY_TOO_MUCH = 2'd2,
      REPLY_CORRUPT  = 2'd3
   } reply_type;

   localparam logic [7:0] HDR_COMMAND = 8'b1000_0001;
   localparam logic [7:0] HDR_REQUEST = 8'b0100_0010;
   localparam logic [7:0] HDR_DATA    = 8'b0010_0100;
   localparam logic [7:0] HDR_STATUS  = 8'b0001_1000;

   typedef struct packed {
      event_type   event_res;
      reply_type   reply_code;
      logic [7:0]  value;
      logic [6:0]  variable;
      logic [7:0]  length;
      logic [6:0]  payload_index;
   } result_type;

endpackage

// ===== hw/rtl/xcfr_parser.sv =====
// ----------------------------------------------------------------------------
// XOR-checked frame parser
// Frame state machine and running check; one result record per received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_parser
   import xcfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   phase_type  phase_ff, phase_in;
   phase_type  prior_ff, prior_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] var_ff, var_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_inc;
   logic       too_long;
   logic       match;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         prior_ff <= PH_WAIT;
      end else if (step) begin
         phase_ff <= phase_in;
         prior_ff <= prior_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= '0;
         count_ff <= '0;
         held_ff  <= '0;
         var_ff   <= '0;
         len_ff   <= '0;
      end else if (step) begin
         check_ff <= check_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         var_ff   <= var_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      too_long  = len_ff > MaxLen;
      match     = rx_byte == check_ff;
      count_inc = count_ff + 8'd1;
      phase_in  = phase_ff;
      prior_in  = prior_ff;
      check_in  = check_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      var_in    = var_ff;
      len_in    = len_ff;
      result    = '0;
      case (phase_ff)
         PH_WAIT: begin
            check_in = rx_byte;
            prior_in = PH_WAIT;
            if (rx_byte == HDR_COMMAND) begin
               phase_in = PH_CMD;
            end else if (rx_byte == HDR_REQUEST) begin
               phase_in = PH_REQ;
            end else if (rx_byte == HDR_DATA) begin
               phase_in = PH_DATVAR;
            end else if (rx_byte == HDR_STATUS) begin
               phase_in = PH_STAT;
            end
         end
         PH_CMD, PH_REQ: begin
            held_in  = rx_byte;
            check_in = check_ff ^ rx_byte;
            prior_in = phase_ff;
            phase_in = PH_CHECK;
         end
         PH_DATVAR: begin
            var_in   = rx_byte;
            check_in = check_ff ^ rx_byte;
            prior_in = PH_DATVAR;
            phase_in = PH_DATLEN;
         end
         PH_DATLEN: begin
            len_in   = rx_byte;
            count_in = '0;
            check_in = check_ff ^ rx_byte;
            prior_in = PH_DATLEN;
            phase_in = (rx_byte == 8'd0) ? PH_CHECK : PH_DAT;
         end
         PH_DAT: begin
            check_in = check_ff ^ rx_byte;
            // An oversized frame is still consumed, but its bytes are not shown.
            if (!too_long) begin
               result.event_res     = EV_PAYLOAD;
               result.value         = rx_byte;
               result.variable      = var_ff[6:0];
               result.length        = len_ff;
               result.payload_index = count_ff[6:0];
            end
            if (count_inc == len_ff) begin
               count_in = '0;
               prior_in = PH_DAT;
               phase_in = PH_CHECK;
            end else begin
               count_in = count_inc;
            end
         end
         PH_STAT: begin
            result.event_res = EV_STATUS;
            result.value     = rx_byte;
            prior_in         = PH_STAT;
            phase_in         = PH_WAIT;
         end
         PH_CHECK: begin
            if (prior_ff == PH_CMD || prior_ff == PH_REQ) begin
               result.value = held_ff;
               if (!match) begin
                  result.event_res  = EV_BADCHK;
                  result.reply_code = REPLY_CORRUPT;
               end else begin
                  result.event_res  = (prior_ff == PH_CMD) ? EV_CMD_OK : EV_REQ_OK;
                  result.reply_code = REPLY_RECEIVED;
               end
            end else if (prior_ff == PH_DAT || prior_ff == PH_DATLEN) begin
               result.variable = var_ff[6:0];
               result.length   = len_ff;
               // Too much data wins over a bad check byte.
               if (too_long) begin
                  result.event_res  = EV_TOOLONG;
                  result.reply_code = REPLY_TOO_MUCH;
               end else if (!match) begin
                  result.event_res  = EV_BADCHK;
                  result.reply_code = REPLY_CORRUPT;
               end else begin
                  result.event_res  = EV_DAT_OK;
                  result.reply_code = REPLY_RECEIVED;
               end
            end
            prior_in = PH_CHECK;
            phase_in = PH_WAIT;
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

endmodule

// ===== hw/rtl/xor_checked_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// XOR-checked frame receiver
// Parses received bytes into command, request, data and status frames and
// reports one event per byte, with payload bytes streamed out by index.
// ----------------------------------------------------------------------------
//   channel   direction  fields
//   req_      in         rx_byte
//   rsp_      out        event_res, reply_code, value, variable, length,
//                        payload_index
//
// Every accepted byte gives exactly one result item in the next cycle.
// One byte per cycle is sustained unless the output stalls; the frame state
// update and the result register sit in a single pass.
// Reset returns the parser to waiting for a header and empties the result.
// A stalled result holds; a new item is still taken in the cycle it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checked_frame_receiver_unit
   import xcfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [1:0] rsp_reply_code,
   output logic [7:0] rsp_value,
   output logic [6:0] rsp_variable,
   output logic [7:0] rsp_length,
   output logic [6:0] rsp_payload_index
);

`include "xor_checked_frame_receiver_unit_assert.svh"

   logic       load;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result;
   result_type result_ff;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign load         = req_valid && !req_stall;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   xcfr_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (load),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = result_ff.event_res;
   assign rsp_reply_code    = result_ff.reply_code;
   assign rsp_value         = result_ff.value;
   assign rsp_variable      = result_ff.variable;
   assign rsp_length        = result_ff.length;
   assign rsp_payload_index = result_ff.payload_index;

   `XCFR_ASSERT_NEXT(a_accept_gives_result, clock, reset, load, rsp_valid)
   `XCFR_ASSERT_SAME(a_full_output_stalls_input, clock, reset,
                     rsp_valid && rsp_stall, req_stall)
   `XCFR_ASSERT_SAME(a_badchk_reply, clock, reset,
                     rsp_valid && rsp_event_res == EV_BADCHK,
                     rsp_reply_code == REPLY_CORRUPT)
   `XCFR_ASSERT_SAME(a_index_in_frame, clock, reset,
                     rsp_valid && rsp_event_res == EV_PAYLOAD,
                     8'(rsp_payload_index) < rsp_length)

endmodule
